// ===== hw/rtl/orbital_density_voxel_eval_macros.svh =====
// Assertion macros used by the checker of the voxel density block.
`ifndef ORBITAL_DENSITY_VOXEL_EVAL_MACROS_SVH
`define ORBITAL_DENSITY_VOXEL_EVAL_MACROS_SVH

// Same-cycle implication.
`define ODVE_ASSERT_IMPL(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ODVE_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/odve_pkg.sv =====
`default_nettype none
package odve_pkg;

    localparam int unsigned MAX_GRID_DEF = 256;
    localparam int unsigned GRID_W       = 9;
    localparam int unsigned IDX_W        = 8;
    localparam int unsigned DENS_W       = 22;
    localparam int unsigned GRID_RST     = 16;

    // coordinate: floor((idx*36*2^17 + d) / 2d) - 18*2^16
    localparam int unsigned NUM_W        = 31;
    localparam logic [30:0] COORD_SCALE  = 31'd4718592;
    localparam logic [31:0] COORD_OFS    = 32'd1179648;
    localparam int unsigned DIV_STEP     = 4;

    localparam int unsigned MAG_W        = 31;
    localparam int unsigned SQ_W         = 62;
    localparam int unsigned R2_W         = 64;
    localparam int unsigned NEAR_W       = 44;   // r2 below 2^44 is the near field
    localparam int unsigned A_W          = 30;

    localparam int unsigned ROOT_W       = 22;
    localparam int unsigned SR_W         = 26;
    localparam int unsigned SQRT_STEP    = 3;

    localparam int unsigned U_W          = 22;
    localparam int unsigned F_W          = 16;
    localparam int unsigned K_W          = 5;
    localparam int unsigned KMAX         = 21;
    localparam int unsigned TERMS        = 12;
    localparam int unsigned T_W          = 32;
    localparam int unsigned SUM_W        = 35;
    localparam int unsigned E_W          = 33;

    localparam logic [31:0] INV3_M       = 32'hAAAAAAAB;
    localparam logic [31:0] INV5_M       = 32'hCCCCCCCD;
    localparam logic [31:0] INV7_M       = 32'd9586981;
    localparam logic [31:0] INV9_M       = 32'd233017;
    localparam logic [31:0] INV11_M      = 32'd5958;
    localparam logic [30:0] INV_E        = 31'd1580030169;
    localparam logic [23:0] C_AMP        = 24'd12213054;
    localparam logic [21:0] DENS_MAX     = 22'h3FFFFF;

    typedef struct packed {
        logic [T_W-1:0]          t;
        logic signed [SUM_W-1:0] sum;
        logic [F_W-1:0]          f;
        logic [K_W-1:0]          k;
    } t_ser;

    // floor(v/n) for the series term divisors; operand ranges shrink with n
    function automatic logic [31:0] div_small(input logic [31:0] v, input int unsigned n);
        logic [63:0] p;
        logic [31:0] res;
        p   = '0;
        res = v;
        case (n)
            2: res = v >> 1;
            3: begin
                p   = 64'(v) * 64'(INV3_M);
                res = 32'(p >> 33);
            end
            4: res = v >> 2;
            5: begin
                p   = 64'(v) * 64'(INV5_M);
                res = 32'(p >> 34);
            end
            6: begin
                p   = 64'(v >> 1) * 64'(INV3_M);
                res = 32'(p >> 33);
            end
            7: begin
                p   = 64'(v) * 64'(INV7_M);
                res = 32'(p >> 26);
            end
            8: res = v >> 3;
            9: begin
                p   = 64'(v) * 64'(INV9_M);
                res = 32'(p >> 21);
            end
            10: begin
                p   = 64'(v >> 1) * 64'(INV5_M);
                res = 32'(p >> 34);
            end
            11: begin
                p   = 64'(v) * 64'(INV11_M);
                res = 32'(p >> 16);
            end
            12: begin
                p   = 64'(v >> 2) * 64'(INV3_M);
                res = 32'(p >> 33);
            end
            default: res = v;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/odve_exp.sv =====
`default_nettype none
// exp(-u), u in Q16, result in Q32: 12-term series on the fraction, then k scalings by 1/e
module odve_exp #(
    parameter int unsigned TAG_W = 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_adv,
    input  wire logic                     i_valid,
    input  wire logic [odve_pkg::U_W-1:0] i_u,
    input  wire logic [TAG_W-1:0]         i_tag,
    output logic                          o_valid,
    output logic [odve_pkg::E_W-1:0]      o_e,
    output logic [TAG_W-1:0]              o_tag
);

    localparam int unsigned NS  = 2 * odve_pkg::TERMS - 1;
    localparam int unsigned TOT = NS + 1 + odve_pkg::KMAX;

    odve_pkg::t_ser                  r_ser [NS];
    logic [odve_pkg::E_W-1:0]        r_e   [odve_pkg::KMAX+1];
    logic [odve_pkg::K_W-1:0]        r_ek  [odve_pkg::KMAX+1];
    logic                            r_v   [TOT];
    logic [TAG_W-1:0]                r_tag [TOT];

    // series start: t1 = f, sum = 1 - t1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_v[0]       <= i_valid;
            r_tag[0]     <= i_tag;
            r_ser[0].f   <= i_u[odve_pkg::F_W-1:0];
            r_ser[0].k   <= odve_pkg::K_W'(i_u >> odve_pkg::F_W);
            r_ser[0].t   <= {i_u[odve_pkg::F_W-1:0], 16'b0};
            r_ser[0].sum <= odve_pkg::SUM_W'(64'h1_0000_0000)
                - odve_pkg::SUM_W'({i_u[odve_pkg::F_W-1:0], 16'b0});
        end
    end

    for (genvar m = 1; m < NS; m++) begin : g_ser
        localparam int unsigned N = (m % 2 == 1) ? (m + 3) / 2 : (m + 2) / 2;
        odve_pkg::t_ser n_ser;
        logic [47:0]    w_prod;
        always_comb begin
            n_ser  = r_ser[m-1];
            w_prod = 48'(r_ser[m-1].t) * 48'(r_ser[m-1].f);
            if (m % 2 == 1) begin
                n_ser.t = odve_pkg::T_W'(w_prod >> 16);
            end else begin
                n_ser.t = odve_pkg::div_small(r_ser[m-1].t, N);
                if (N % 2 == 1) begin
                    n_ser.sum = r_ser[m-1].sum - odve_pkg::SUM_W'(n_ser.t);
                end else begin
                    n_ser.sum = r_ser[m-1].sum + odve_pkg::SUM_W'(n_ser.t);
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[m] <= 1'b0;
            end else if (i_adv) begin
                r_v[m]   <= r_v[m-1];
                r_tag[m] <= r_tag[m-1];
                r_ser[m] <= n_ser;
            end
        end
    end

    // clamp to [0, 1.0]
    logic [odve_pkg::E_W-1:0] n_e0;
    always_comb begin
        if (r_ser[NS-1].sum < 0) begin
            n_e0 = '0;
        end else if (r_ser[NS-1].sum > odve_pkg::SUM_W'(64'h1_0000_0000)) begin
            n_e0 = odve_pkg::E_W'(64'h1_0000_0000);
        end else begin
            n_e0 = odve_pkg::E_W'(r_ser[NS-1].sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[NS] <= 1'b0;
        end else if (i_adv) begin
            r_v[NS]   <= r_v[NS-1];
            r_tag[NS] <= r_tag[NS-1];
            r_e[0]    <= n_e0;
            r_ek[0]   <= r_ser[NS-1].k;
        end
    end

    for (genvar j = 0; j < odve_pkg::KMAX; j++) begin : g_kstep
        logic [odve_pkg::E_W-1:0] n_e;
        logic [63:0]              w_prod;
        always_comb begin
            w_prod = 64'(r_e[j]) * 64'(odve_pkg::INV_E) + 64'h8000_0000;
            if (odve_pkg::K_W'(j) < r_ek[j]) begin
                n_e = odve_pkg::E_W'(w_prod >> 32);
            end else begin
                n_e = r_e[j];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[NS+1+j] <= 1'b0;
            end else if (i_adv) begin
                r_v[NS+1+j]   <= r_v[NS+j];
                r_tag[NS+1+j] <= r_tag[NS+j];
                r_e[j+1]      <= n_e;
                r_ek[j+1]     <= r_ek[j];
            end
        end
    end

    assign o_valid = r_v[TOT-1];
    assign o_tag   = r_tag[TOT-1];
    assign o_e     = r_e[odve_pkg::KMAX];

endmodule
`default_nettype wire

// ===== hw/rtl/orbital_density_voxel_eval.sv =====
// Hydrogen 3d_z2 orbital density per voxel. One voxel index triple is taken every cycle
// while o_stall is low; its density leaves a pipeline of stages numerator 1, coordinate
// divider 8, squares 1, sum 1, square root 8, exponent argument 1, exponential 45,
// amplitude 2 and output 1; the depth comes from the bit-serial coordinate divider, the
// digit-by-digit square root and the one-step-per-stage exponential series and 1/e scalings.
// The whole pipeline holds while a finished beat is stalled at the output; bubbles still
// advance otherwise. grid_size is written through the config channel, always ready, and
// must only change while the pipeline is empty. Voxels at radius 64 or more give zero.
`default_nettype none
module orbital_density_voxel_eval #(
    parameter int unsigned MAX_GRID = odve_pkg::MAX_GRID_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [odve_pkg::GRID_W-1:0] i_cfg_data,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [odve_pkg::IDX_W-1:0]  i_voxel_x,
    input  wire logic [odve_pkg::IDX_W-1:0]  i_voxel_y,
    input  wire logic [odve_pkg::IDX_W-1:0]  i_voxel_z,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [odve_pkg::DENS_W-1:0]      o_density
);

    localparam int unsigned D_W    = $clog2(MAX_GRID);
    localparam int unsigned RM_W   = D_W + 2;
    localparam int unsigned D_RST  =
        ((odve_pkg::GRID_RST > MAX_GRID) ? MAX_GRID : odve_pkg::GRID_RST) - 1;
    localparam int unsigned NUM_W  = odve_pkg::NUM_W;
    localparam int unsigned DIV_ST = (NUM_W + odve_pkg::DIV_STEP - 1) / odve_pkg::DIV_STEP;
    localparam int unsigned SQ_ST  =
        (odve_pkg::ROOT_W + odve_pkg::SQRT_STEP - 1) / odve_pkg::SQRT_STEP;
    localparam int unsigned TAG_W  = odve_pkg::A_W + 1;
    localparam int unsigned NW     = odve_pkg::NEAR_W;
    localparam int unsigned SR_W   = odve_pkg::SR_W;
    localparam int unsigned RT_W   = odve_pkg::ROOT_W;

    // ---- config ----
    logic [D_W-1:0] r_d, n_d;

    always_comb begin
        if (i_cfg_data < odve_pkg::GRID_W'(2)) begin
            n_d = D_W'(1);
        end else if (32'(i_cfg_data) > MAX_GRID) begin
            n_d = D_W'(MAX_GRID - 1);
        end else begin
            n_d = D_W'(i_cfg_data - odve_pkg::GRID_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= D_W'(D_RST);
        end else if (i_cfg_valid) begin
            r_d <= n_d;
        end
    end

    assign o_cfg_ready = 1'b1;

    // ---- flow control ----
    logic w_adv;
    logic r_o_valid;
    assign w_adv   = !r_o_valid || !i_stall;
    assign o_stall = !w_adv;

    // ---- numerator and bit-serial divide by 2d ----
    logic [RM_W-1:0]           w_dvsr;
    logic [odve_pkg::IDX_W-1:0] w_idx [3];
    logic                      r_dv_v   [DIV_ST+1];
    logic [NUM_W-1:0]          r_dv_num [DIV_ST+1][3];
    logic [RM_W-1:0]           r_dv_rem [DIV_ST+1][3];

    assign w_dvsr = RM_W'({r_d, 1'b0});

    always_comb begin
        w_idx[0] = i_voxel_x;
        w_idx[1] = i_voxel_y;
        w_idx[2] = i_voxel_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv_v[0] <= i_valid;
            for (int a = 0; a < 3; a++) begin
                r_dv_num[0][a] <= NUM_W'(32'(odve_pkg::COORD_SCALE) * 32'(w_idx[a]))
                    + NUM_W'(r_d);
                r_dv_rem[0][a] <= '0;
            end
        end
    end

    for (genvar s = 1; s <= DIV_ST; s++) begin : g_div
        logic [NUM_W-1:0] n_num [3];
        logic [RM_W-1:0]  n_rem [3];
        always_comb begin
            for (int a = 0; a < 3; a++) begin
                n_num[a] = r_dv_num[s-1][a];
                n_rem[a] = r_dv_rem[s-1][a];
                for (int j = 0; j < odve_pkg::DIV_STEP; j++) begin
                    if ((s - 1) * odve_pkg::DIV_STEP + j < NUM_W) begin
                        n_rem[a] = {n_rem[a][RM_W-2:0], n_num[a][NUM_W-1]};
                        n_num[a] = {n_num[a][NUM_W-2:0], 1'b0};
                        if (n_rem[a] >= w_dvsr) begin
                            n_rem[a]    = n_rem[a] - w_dvsr;
                            n_num[a][0] = 1'b1;
                        end
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[s] <= 1'b0;
            end else if (w_adv) begin
                r_dv_v[s]   <= r_dv_v[s-1];
                r_dv_num[s] <= n_num;
                r_dv_rem[s] <= n_rem;
            end
        end
    end

    // ---- coordinate magnitude and squares ----
    logic                      r_sq_v;
    logic [odve_pkg::SQ_W-1:0] r_sq [3];
    logic [odve_pkg::SQ_W-1:0] n_sq [3];

    always_comb begin
        logic signed [31:0]         p;
        logic [odve_pkg::MAG_W-1:0] mg;
        for (int a = 0; a < 3; a++) begin
            p = signed'(32'(r_dv_num[DIV_ST][a])) - signed'(odve_pkg::COORD_OFS);
            if (p < 0) begin
                mg = odve_pkg::MAG_W'(-p);
            end else begin
                mg = odve_pkg::MAG_W'(p);
            end
            n_sq[a] = odve_pkg::SQ_W'(mg) * odve_pkg::SQ_W'(mg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
        end else if (w_adv) begin
            r_sq_v <= r_dv_v[DIV_ST];
            r_sq   <= n_sq;
        end
    end

    // ---- r^2, far check, angular term ----
    logic [odve_pkg::R2_W-1:0] w_r2;
    logic signed [NW+1:0]      w_am;
    logic [NW:0]               w_amag;
    logic [TAG_W-1:0]          n_tag0;

    always_comb begin
        w_r2 = odve_pkg::R2_W'(r_sq[0]) + odve_pkg::R2_W'(r_sq[1])
            + odve_pkg::R2_W'(r_sq[2]);
        w_am = signed'({1'b0, r_sq[2][NW-1:0], 1'b0}) - signed'({2'b0, r_sq[0][NW-1:0]})
            - signed'({2'b0, r_sq[1][NW-1:0]});
        if (w_am < 0) begin
            w_amag = (NW+1)'(-w_am);
        end else begin
            w_amag = (NW+1)'(w_am);
        end
        n_tag0 = {(|w_r2[odve_pkg::R2_W-1:NW]),
                  odve_pkg::A_W'(((NW+2)'(w_amag) + (NW+2)'(32768)) >> 16)};
    end

    // ---- digit-by-digit square root ----
    logic             r_sr_v    [SQ_ST+1];
    logic [NW-1:0]    r_sr_rad  [SQ_ST+1];
    logic [SR_W-1:0]  r_sr_rem  [SQ_ST+1];
    logic [RT_W-1:0]  r_sr_root [SQ_ST+1];
    logic [TAG_W-1:0] r_sr_tag  [SQ_ST+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_sr_v[0]    <= r_sq_v;
            r_sr_rad[0]  <= w_r2[NW-1:0];
            r_sr_rem[0]  <= '0;
            r_sr_root[0] <= '0;
            r_sr_tag[0]  <= n_tag0;
        end
    end

    for (genvar s = 1; s <= SQ_ST; s++) begin : g_sqrt
        logic [NW-1:0]   n_rad;
        logic [SR_W-1:0] n_rem;
        logic [RT_W-1:0] n_root;
        logic [SR_W-1:0] w_trial;
        always_comb begin
            n_rad   = r_sr_rad[s-1];
            n_rem   = r_sr_rem[s-1];
            n_root  = r_sr_root[s-1];
            w_trial = '0;
            for (int j = 0; j < odve_pkg::SQRT_STEP; j++) begin
                if ((s - 1) * odve_pkg::SQRT_STEP + j < RT_W) begin
                    n_rem   = {n_rem[SR_W-3:0], n_rad[NW-1:NW-2]};
                    n_rad   = {n_rad[NW-3:0], 2'b00};
                    w_trial = SR_W'({n_root, 2'b01});
                    if (n_rem >= w_trial) begin
                        n_rem  = n_rem - w_trial;
                        n_root = {n_root[RT_W-2:0], 1'b1};
                    end else begin
                        n_root = {n_root[RT_W-2:0], 1'b0};
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sr_v[s] <= 1'b0;
            end else if (w_adv) begin
                r_sr_v[s]    <= r_sr_v[s-1];
                r_sr_rad[s]  <= n_rad;
                r_sr_rem[s]  <= n_rem;
                r_sr_root[s] <= n_root;
                r_sr_tag[s]  <= r_sr_tag[s-1];
            end
        end
    end

    // ---- u = (r + 1) / 3 ----
    logic                     r_u_v;
    logic [odve_pkg::U_W-1:0] r_u;
    logic [TAG_W-1:0]         r_u_tag;
    logic [54:0]              w_u_prod;

    assign w_u_prod = (55'(r_sr_root[SQ_ST]) + 55'(1)) * 55'(odve_pkg::INV3_M);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_v <= 1'b0;
        end else if (w_adv) begin
            r_u_v   <= r_sr_v[SQ_ST];
            r_u     <= odve_pkg::U_W'(w_u_prod >> 33);
            r_u_tag <= r_sr_tag[SQ_ST];
        end
    end

    // ---- exponential ----
    logic                     w_e_v;
    logic [odve_pkg::E_W-1:0] w_e;
    logic [TAG_W-1:0]         w_e_tag;

    odve_exp #(
        .TAG_W (TAG_W)
    ) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_u_v),
        .i_u     (r_u),
        .i_tag   (r_u_tag),
        .o_valid (w_e_v),
        .o_e     (w_e),
        .o_tag   (w_e_tag)
    );

    // ---- amplitude ----
    logic        r_q_v;
    logic [30:0] r_q;
    logic        r_q_far;
    logic [63:0] w_q_prod;

    assign w_q_prod = 64'(w_e_tag[odve_pkg::A_W-1:0]) * 64'(w_e) + 64'h8000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v <= 1'b0;
        end else if (w_adv) begin
            r_q_v   <= w_e_v;
            r_q     <= 31'(w_q_prod >> 32);
            r_q_far <= w_e_tag[TAG_W-1];
        end
    end

    logic        r_s_v;
    logic [31:0] r_s;
    logic        r_s_far;
    logic [54:0] w_s_prod;
    logic [38:0] w_s_sh;

    assign w_s_prod = 55'(r_q) * 55'(odve_pkg::C_AMP) + 55'(32768);
    assign w_s_sh   = 39'(w_s_prod >> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (w_adv) begin
            r_s_v   <= r_q_v;
            r_s     <= (|w_s_sh[38:32]) ? 32'hFFFF_FFFF : w_s_sh[31:0];
            r_s_far <= r_q_far;
        end
    end

    // ---- density ----
    logic [64:0]                 w_d_prod;
    logic [32:0]                 w_d_sh;
    logic [odve_pkg::DENS_W-1:0] n_dens;
    logic [odve_pkg::DENS_W-1:0] r_o_density;

    always_comb begin
        w_d_prod = 65'(64'(r_s) * 64'(r_s)) + 65'(64'h8000_0000);
        w_d_sh   = 33'(w_d_prod >> 32);
        if (r_s_far) begin
            n_dens = '0;
        end else if (w_d_sh > 33'(odve_pkg::DENS_MAX)) begin
            n_dens = odve_pkg::DENS_MAX;
        end else begin
            n_dens = w_d_sh[odve_pkg::DENS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid   <= r_s_v;
            r_o_density <= n_dens;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_density = r_o_density;

endmodule
`default_nettype wire

// ===== hw/rtl/odve_checker.sv =====
`default_nettype none
`include "orbital_density_voxel_eval_macros.svh"
module odve_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_stall,
    input wire logic                        o_valid,
    input wire logic                        i_stall,
    input wire logic [odve_pkg::DENS_W-1:0] o_density
);

    `ODVE_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_valid && i_stall, o_valid, "beat dropped")
    `ODVE_ASSERT_NEXT(a_out_stable, i_clk, !i_rst_n, o_valid && i_stall, $stable(o_density), "stalled beat changed")
    `ODVE_ASSERT_IMPL(a_stall_cause, i_clk, !i_rst_n, o_stall, o_valid && i_stall, "input stalled without output backpressure")
    `ODVE_ASSERT_NEXT(a_rst_flush, i_clk, 1'b0, !i_rst_n, !o_valid, "valid beat after reset")

endmodule

bind orbital_density_voxel_eval odve_checker u_odve_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_density (o_density)
);
`default_nettype wire

// ===== tb/orbital_density_voxel_eval_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module orbital_density_voxel_eval_test;

    localparam int LIMIT = 1000000;
    localparam int DRAIN = 100;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [odve_pkg::GRID_W-1:0]   cfg_data = '0;
    logic                          vox_valid = 1'b0;
    logic                          vox_stall;
    logic [odve_pkg::IDX_W-1:0]    vox_x = '0;
    logic [odve_pkg::IDX_W-1:0]    vox_y = '0;
    logic [odve_pkg::IDX_W-1:0]    vox_z = '0;
    logic                          dens_valid;
    logic                          dens_stall = 1'b0;
    logic [odve_pkg::DENS_W-1:0]   dens;

    logic [odve_pkg::DENS_W-1:0]   density_q[$];
    logic [odve_pkg::GRID_W-1:0]   grid_cur;
    int                            n_fail = 0;
    int                            cycles = 0;
    int                            idle_pct = 0;
    int                            stall_pct = 0;

    orbital_density_voxel_eval u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_valid(vox_valid), .o_stall(vox_stall),
        .i_voxel_x(vox_x), .i_voxel_y(vox_y), .i_voxel_z(vox_z),
        .o_valid(dens_valid), .i_stall(dens_stall), .o_density(dens)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("orbital_density_voxel_eval_test: FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin
        dens_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && dens_valid && !dens_stall) begin
            if (density_q.size() == 0) begin
                $error("density beat with nothing expected: %0d", dens);
                n_fail++;
            end else begin
                if (dens !== density_q[0]) begin
                    $error("density mismatch: expected %0d actual %0d", density_q[0], dens);
                    n_fail++;
                end
                void'(density_q.pop_front());
            end
        end
    end

    function automatic longint signed voxel_coord(logic [7:0] idx, longint unsigned d);
        longint unsigned num;
        num = longint'(idx) * 36 * 65536 * 2 + d;
        return longint'(num / (2 * d)) - 18 * 65536;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned exp_neg(longint unsigned u);
        longint unsigned k, f, t, e;
        longint signed   sum;
        k = u >> 16;
        f = u & 64'hFFFF;
        t = 64'd1 << 32;
        sum = longint'(t);
        for (int n = 1; n <= 12; n++) begin
            t = ((t * f) >> 16) / n;
            if (n % 2) sum -= longint'(t);
            else sum += longint'(t);
        end
        if (sum < 0) sum = 0;
        if (sum > (64'sd1 <<< 32)) sum = 64'sd1 <<< 32;
        e = sum;
        repeat (k) e = (e * 64'd1580030169 + (64'd1 << 31)) >> 32;
        return e;
    endfunction

    function automatic logic [odve_pkg::DENS_W-1:0] orbital_density(logic [7:0] ix,
                                                                   logic [7:0] iy,
                                                                   logic [7:0] iz);
        longint unsigned g, d, x2, y2, z2, r2, r, a, e, q, s, dv;
        longint signed   px, py, pz, am;
        g = grid_cur;
        if (g < 2) g = 2;
        if (g > 256) g = 256;
        d = g - 1;
        px = voxel_coord(ix, d);
        py = voxel_coord(iy, d);
        pz = voxel_coord(iz, d);
        x2 = px * px;
        y2 = py * py;
        z2 = pz * pz;
        r2 = x2 + y2 + z2;
        if (r2 >= (64'd1 << 44)) return '0;
        r = int_sqrt(r2);
        am = 2 * longint'(z2) - longint'(x2) - longint'(y2);
        a = ((am < 0 ? -am : am) + (64'd1 << 15)) >> 16;
        e = exp_neg((r + 1) / 3);
        q = (a * e + (64'd1 << 31)) >> 32;
        s = (q * 64'd12213054 + (64'd1 << 15)) >> 16;
        if (s > 64'hFFFFFFFF) s = 64'hFFFFFFFF;
        dv = (s * s + (64'd1 << 31)) >> 32;
        if (dv > 64'd4194303) dv = 64'd4194303;
        return dv[odve_pkg::DENS_W-1:0];
    endfunction

    task automatic send_voxel(logic [7:0] ix, logic [7:0] iy, logic [7:0] iz);
        while ($urandom_range(99) < idle_pct) begin
            vox_valid <= 1'b0;
            @(posedge clk);
        end
        vox_valid <= 1'b1;
        vox_x <= ix;
        vox_y <= iy;
        vox_z <= iz;
        @(posedge clk);
        while (vox_stall) @(posedge clk);
        density_q.push_back(orbital_density(ix, iy, iz));
    endtask

    task automatic wait_drain();
        vox_valid <= 1'b0;
        while (density_q.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic set_grid(logic [odve_pkg::GRID_W-1:0] g);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data <= g;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        grid_cur = g;
        @(posedge clk);
    endtask

    task automatic test_directed();
        set_grid(9'd16);
        send_voxel(8'd0, 8'd0, 8'd0);
        send_voxel(8'd15, 8'd15, 8'd15);
        send_voxel(8'd7, 8'd8, 8'd8);
        send_voxel(8'd8, 8'd7, 8'd7);
        send_voxel(8'd7, 8'd7, 8'd10);
        send_voxel(8'd255, 8'd255, 8'd255);
        send_voxel(8'd8, 8'd8, 8'd20);
        set_grid(9'd256);
        send_voxel(8'd127, 8'd128, 8'd128);
        send_voxel(8'd128, 8'd128, 8'd160);
        send_voxel(8'd255, 8'd0, 8'd128);
        send_voxel(8'd0, 8'd255, 8'd255);
        set_grid(9'd4);
        send_voxel(8'd1, 8'd2, 8'd1);
        send_voxel(8'd3, 8'd3, 8'd0);
        set_grid(9'd0);
        send_voxel(8'd0, 8'd0, 8'd1);
        send_voxel(8'd1, 8'd1, 8'd1);
        set_grid(9'd1);
        send_voxel(8'd0, 8'd1, 8'd0);
        set_grid(9'h1FF);
        send_voxel(8'd128, 8'd127, 8'd140);
        send_voxel(8'd170, 8'd85, 8'd85);
    endtask

    task automatic test_random(int n);
        logic [odve_pkg::GRID_W-1:0] g;
        logic [7:0]                  lim;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(3))
                    0: g = 9'd4;
                    1: g = 9'd256;
                    2: g = 9'($urandom_range(4, 64));
                    default: g = 9'($urandom);
                endcase
                set_grid(g);
            end
            lim = (grid_cur >= 2 && grid_cur <= 256) ? 8'(grid_cur - 1) : 8'd255;
            if ($urandom_range(9) == 0)
                send_voxel(8'($urandom), 8'($urandom), 8'($urandom));
            else
                send_voxel(8'($urandom_range(lim)), 8'($urandom_range(lim)),
                           8'($urandom_range(lim)));
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        idle_pct = 0;  stall_pct = 0;  test_random(110);
        idle_pct = 58; stall_pct = 0;  test_random(110);
        idle_pct = 0;  stall_pct = 58; test_random(110);
        idle_pct = 13; stall_pct = 13; test_random(120);
        stall_pct = 0;
        wait_drain();
        if (n_fail == 0) $display("orbital_density_voxel_eval_test: PASS");
        else $display("orbital_density_voxel_eval_test: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/odve_pkg.sv
hw/rtl/odve_exp.sv
hw/rtl/orbital_density_voxel_eval.sv
hw/rtl/odve_checker.sv
tb/orbital_density_voxel_eval_test.sv
